[hdl/mrpt_pkg.sv]
// Package: shared types and constants for the Miller-Rabin prime tester.
package mrpt_pkg;
	localparam int MAX_BASES = 12;
	localparam int BASE_W = 6;
	typedef logic [BASE_W-1:0] base_t;

	function automatic base_t prime_base(input logic [3:0] idx);
		base_t b;
		case (idx)
			4'd0: b = 6'd2;
			4'd1: b = 6'd3;
			4'd2: b = 6'd5;
			4'd3: b = 6'd7;
			4'd4: b = 6'd11;
			4'd5: b = 6'd13;
			4'd6: b = 6'd17;
			4'd7: b = 6'd19;
			4'd8: b = 6'd23;
			4'd9: b = 6'd29;
			4'd10: b = 6'd31;
			4'd11: b = 6'd37;
			default: b = 6'd37;
		endcase
		return b;
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} mm_ctrl_t;
endpackage

[hdl/mrpt_if.sv]
// Interfaces: valid/ready channels for candidate and result.
interface mrpt_in_if #(parameter int WIDTH = 64);
	logic valid;
	logic ready;
	logic [WIDTH-1:0] candidate;
	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if;
	logic valid;
	logic ready;
	logic is_prime;
	modport source (output valid, output is_prime, input ready);
	modport sink (input valid, input is_prime, output ready);
endinterface

[hdl/mrpt_mulmod.sv]
// Shift-and-subtract modular multiplier, one bit of b per cycle.
module mrpt_mulmod #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic [WIDTH-1:0] result,
	output mrpt_pkg::mm_ctrl_t ctrl
);
	import mrpt_pkg::*;
	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] acc_q, a_q, b_q, m_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [WIDTH-1:0] dbl, sum, gap1, gap2;

	always_comb begin
		gap1 = m_q - acc_q;
		dbl  = (acc_q >= gap1) ? (acc_q - gap1) : (acc_q + acc_q);
		gap2 = m_q - a_q;
		if (b_q[WIDTH-1])
			sum = (dbl >= gap2) ? (dbl - gap2) : (dbl + a_q);
		else
			sum = dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH-1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= sum;
			b_q   <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign result     = acc_q;
	assign ctrl.start = start;
	assign ctrl.busy  = busy_q;
	assign ctrl.done  = done_q;
endmodule

[hdl/miller_rabin_prime_test.sv]
// Top level: deterministic Miller-Rabin primality tester.
// Channels: in_ch (candidate) and out_ch (is_prime), valid/ready; a
// transaction happens when valid and ready are both high at a rising edge.
// One candidate is processed at a time; in_ch.ready is low while busy.
// Trivial cases (below 4 or even) go straight to the result. Otherwise each
// base needs a power a^d mod n by square-and-multiply (one modular product
// per exponent bit, two for a set bit) and up to s-1 squarings. Every
// modular product runs on the single shared shift-and-subtract multiplier.
// The result is held in an output register until out_ch takes it; a new
// candidate is accepted in the cycle after the result is taken at the
// earliest. Reset (arst_n low) clears the sequencer, drops out_ch.valid
// and raises in_ch.ready.
// No state is kept between candidates.
module miller_rabin_prime_test #(
	parameter int WIDTH = 64,
	parameter int NUM_BASES = 12
) (
	input  logic clk,
	input  logic arst_n,
	mrpt_in_if.sink    in_ch,
	mrpt_out_if.source out_ch
);
	import mrpt_pkg::*;
	localparam int SW = $clog2(WIDTH);
	localparam int CW = $clog2(WIDTH+1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SPLIT = 3'd1;
	localparam logic [2:0] ST_BASE = 3'd2;
	localparam logic [2:0] ST_POW = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_CHECK = 3'd5;
	localparam logic [2:0] ST_SQ = 3'd6;
	localparam logic [2:0] ST_OUT = 3'd7;

	localparam logic [1:0] OP_MUL = 2'd0;
	localparam logic [1:0] OP_SQB = 2'd1;
	localparam logic [1:0] OP_SQX = 2'd2;

	logic [2:0]       state_q;
	logic [1:0]       op_q;
	logic [WIDTH-1:0] n_q, d_q, e_q, acc_q, sq_q, x_q;
	logic [SW-1:0]    s_q, r_q;
	logic [3:0]       k_q;
	logic             res_q;
	logic             mm_start;
	logic [WIDTH-1:0] mm_a, mm_b, mm_res, nm1, base_ext;
	mm_ctrl_t         mm_ctrl;

	assign nm1 = n_q - 1'b1;
	assign base_ext = WIDTH'(prime_base(k_q));

	mrpt_mulmod #(.WIDTH(WIDTH)) u_mm (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.a(mm_a), .b(mm_b), .m(n_q), .result(mm_res), .ctrl(mm_ctrl)
	);

	always_comb begin
		mm_start = 1'b0;
		mm_a = sq_q;
		mm_b = sq_q;
		if (state_q == ST_POW) begin
			mm_start = 1'b1;
			if (e_q[0]) begin
				mm_a = acc_q;
				mm_b = sq_q;
			end
		end else if (state_q == ST_SQ) begin
			mm_start = 1'b1;
			mm_a = x_q;
			mm_b = x_q;
		end
	end

	assign in_ch.ready     = (state_q == ST_IDLE);
	assign out_ch.valid    = (state_q == ST_OUT);
	assign out_ch.is_prime = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_MUL;
			k_q <= '0;
			s_q <= '0;
			r_q <= '0;
			res_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					if (in_ch.candidate < WIDTH'(2)) begin
						res_q <= 1'b0;
						state_q <= ST_OUT;
					end else if (in_ch.candidate < WIDTH'(4)) begin
						res_q <= 1'b1;
						state_q <= ST_OUT;
					end else if (!in_ch.candidate[0]) begin
						res_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						s_q <= '0;
						k_q <= '0;
						res_q <= 1'b1;
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: if (d_q[0]) begin
					state_q <= ST_BASE;
				end else begin
					s_q <= s_q + 1'b1;
				end
				ST_BASE: begin
					if (k_q == 4'(NUM_BASES) || n_q <= base_ext)
						state_q <= ST_OUT;
					else
						state_q <= (d_q == '0) ? ST_CHECK : ST_POW;
				end
				ST_POW: begin
					op_q <= e_q[0] ? OP_MUL : OP_SQB;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (mm_ctrl.done) begin
					case (op_q)
						OP_MUL: begin
							op_q <= OP_SQB;
							state_q <= ST_POW;
						end
						OP_SQB: state_q <= (e_q == '0) ? ST_CHECK : ST_POW;
						OP_SQX: begin
							if (mm_res == nm1) begin
								k_q <= k_q + 1'b1;
								state_q <= ST_BASE;
							end else if (CW'(r_q) + 1'b1 >= CW'(s_q)) begin
								res_q <= 1'b0;
								state_q <= ST_OUT;
							end else begin
								r_q <= r_q + 1'b1;
								state_q <= ST_SQ;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_CHECK: begin
					if (acc_q == WIDTH'(1) || acc_q == nm1) begin
						k_q <= k_q + 1'b1;
						state_q <= ST_BASE;
					end else if (s_q <= SW'(1)) begin
						res_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						r_q <= SW'(1);
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					op_q <= OP_SQX;
					state_q <= ST_WAIT;
				end
				ST_OUT: if (out_ch.ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pow state: op MUL (for a set bit) then SQB per exponent bit; SQB consumes the bit
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_ch.valid) begin
				n_q <= in_ch.candidate;
				d_q <= in_ch.candidate - 1'b1;
			end
			ST_SPLIT: if (!d_q[0]) d_q <= d_q >> 1;
			ST_BASE: begin
				e_q <= d_q;
				acc_q <= WIDTH'(1);
				sq_q <= base_ext;
			end
			ST_POW: if (!e_q[0]) e_q <= e_q >> 1;
			ST_WAIT: if (mm_ctrl.done) begin
				case (op_q)
					OP_MUL: begin
						acc_q <= mm_res;
						e_q <= {e_q[WIDTH-1:1], 1'b0};
					end
					OP_SQB: sq_q <= mm_res;
					OP_SQX: x_q <= mm_res;
					default: ;
				endcase
			end
			ST_CHECK: x_q <= acc_q;
			default: ;
		endcase
	end
endmodule

[hdl/mrpt_checker.sv]
// Checker: port-level properties of the prime tester, bound to the top level.
module mrpt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_prime
);
	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(is_prime))
		else $error("result dropped or changed");
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted twice");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result repeated");
endmodule

bind miller_rabin_prime_test mrpt_checker u_mrpt_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.is_prime(out_ch.is_prime)
);
